FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Check that the consequent holds a fixed number of cycles after the antecedent.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error("delayed check failed");

`endif

FILE: sv/eul_pkg.sv
package eul_pkg;

	// Extra fraction bits carried through the datapath
	localparam int GUARD_BITS = 8;

	// Micro-rotations are capped at the table length
	localparam int MAX_STAGES = 24;

	// CORDIC gain compensation, 0.607252935 in Q0.32
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	// atan(2^-i) with 2^32 per turn, rounded to nearest
	localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Quadrant of the pre-rotation
	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

endpackage

FILE: sv/eul_rot.sv
`include "assert_macros.svh"

// Rotate the pair (a, b) by a binary angle: a' = a*c - b*s, b' = a*s + b*c.
// One quadrant stage, one stage per micro-rotation, four gain stages.
module eul_rot #(
	parameter int IW = 43,
	parameter int ANGLE_BITS = 16,
	parameter int NST = 16,
	parameter int PW = 75
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [IW-1:0]  a_in,
	input  logic signed [IW-1:0]  b_in,
	input  logic [ANGLE_BITS-1:0] angle,
	input  logic [PW-1:0]         side_in,
	output logic                  out_valid,
	output logic signed [IW-1:0]  a_out,
	output logic signed [IW-1:0]  b_out,
	output logic [PW-1:0]         side_out
);
	import eul_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam int MAGW = (IW > 33) ? IW : 33;
	localparam int LAT = NST + 5;
	localparam logic [AB-1:0] EIGHTH = AB'(1) << (AB - 3);

	// front: quadrant pre-rotation and residual angle
	logic [AB-1:0]        t;
	logic [AB-3:0]        res;
	logic signed [31:0]   z0;
	logic signed [IW-1:0] qa;
	logic signed [IW-1:0] qb;

	always_comb begin
		t = angle + EIGHTH;
		res = {~t[AB-3], t[AB-4:0]};
		z0 = {{2{res[AB-3]}}, res, {(32-AB){1'b0}}};
		case (quad_t'(t[AB-1:AB-2]))
			QUAD_0: begin
				qa = a_in;
				qb = b_in;
			end
			QUAD_90: begin
				qa = -b_in;
				qb = a_in;
			end
			QUAD_180: begin
				qa = -a_in;
				qb = -b_in;
			end
			QUAD_270: begin
				qa = b_in;
				qb = -a_in;
			end
			default: begin
				qa = a_in;
				qb = b_in;
			end
		endcase
	end

	// micro-rotation pipeline; index 0 is the quadrant stage
	logic                 cor_v_s    [NST+1];
	logic signed [IW-1:0] cor_a_s    [NST+1];
	logic signed [IW-1:0] cor_b_s    [NST+1];
	logic signed [31:0]   cor_z_s    [NST+1];
	logic                 cor_byp_s  [NST+1];
	logic [PW-1:0]        cor_side_s [NST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_v_s[0] <= 1'b0;
		end else begin
			cor_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cor_a_s[0]    <= qa;
		cor_b_s[0]    <= qb;
		cor_z_s[0]    <= z0;
		cor_byp_s[0]  <= (res == '0);
		cor_side_s[0] <= side_in;
	end

	for (genvar i = 0; i < NST; i++) begin : g_cor
		localparam logic signed [31:0] ATAN_I = $signed(ATAN_TAB[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_v_s[i+1] <= 1'b0;
			end else begin
				cor_v_s[i+1] <= cor_v_s[i];
			end
		end

		// step toward zero residual; hold on exact quarter turns
		always_ff @(posedge clk) begin
			cor_byp_s[i+1]  <= cor_byp_s[i];
			cor_side_s[i+1] <= cor_side_s[i];
			if (cor_byp_s[i]) begin
				cor_a_s[i+1] <= cor_a_s[i];
				cor_b_s[i+1] <= cor_b_s[i];
				cor_z_s[i+1] <= cor_z_s[i];
			end else if (!cor_z_s[i][31]) begin
				cor_a_s[i+1] <= cor_a_s[i] - (cor_b_s[i] >>> i);
				cor_b_s[i+1] <= cor_b_s[i] + (cor_a_s[i] >>> i);
				cor_z_s[i+1] <= cor_z_s[i] - ATAN_I;
			end else begin
				cor_a_s[i+1] <= cor_a_s[i] + (cor_b_s[i] >>> i);
				cor_b_s[i+1] <= cor_b_s[i] - (cor_a_s[i] >>> i);
				cor_z_s[i+1] <= cor_z_s[i] + ATAN_I;
			end
		end
	end

	// gain compensation lanes: 0 carries a, 1 carries b
	logic signed [IW-1:0] fin [2];
	logic [MAGW:0]        ext [2];
	logic [MAGW:0]        absv [2];
	logic [63:0]          rnd [2];
	logic [MAGW-1:0]      gval [2];
	logic signed [MAGW:0] sv [2];
	logic signed [MAGW:0] sres [2];

	logic                 v_s2, v_s3, v_s4, v_s5;
	logic                 byp_s2, byp_s3;
	logic [PW-1:0]        side_s2, side_s3, side_s4, side_s5;
	logic                 neg_s2 [2];
	logic                 neg_s3 [2];
	logic                 neg_s4 [2];
	logic [MAGW-1:0]      mag_s2 [2];
	logic [MAGW-1:0]      mag_s3 [2];
	logic [MAGW-1:0]      mag_s4 [2];
	logic [63:0]          plo_s3 [2];
	logic [MAGW-1:0]      phi_s3 [2];
	logic signed [IW-1:0] out_s5 [2];

	assign fin[0] = cor_a_s[NST];
	assign fin[1] = cor_b_s[NST];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			ext[k] = {{(MAGW+1-IW){fin[k][IW-1]}}, fin[k]};
			absv[k] = fin[k][IW-1] ? (~ext[k] + 1'b1) : ext[k];
			rnd[k] = plo_s3[k] + 64'h8000_0000;
			gval[k] = phi_s3[k] + MAGW'(rnd[k][63:32]);
			sv[k] = $signed({1'b0, mag_s4[k]});
			sres[k] = neg_s4[k] ? -sv[k] : sv[k];
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= cor_v_s[NST];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// magnitude, split multiply, round (bypassed on exact quarter turns), restore sign
	always_ff @(posedge clk) begin
		byp_s2  <= cor_byp_s[NST];
		byp_s3  <= byp_s2;
		side_s2 <= cor_side_s[NST];
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		for (int k = 0; k < 2; k++) begin
			neg_s2[k] <= fin[k][IW-1];
			mag_s2[k] <= absv[k][MAGW-1:0];
			neg_s3[k] <= neg_s2[k];
			mag_s3[k] <= mag_s2[k];
			plo_s3[k] <= 64'(mag_s2[k][31:0]) * 64'(GAIN_Q32);
			phi_s3[k] <= MAGW'(mag_s2[k][MAGW-1:32]) * MAGW'(GAIN_Q32);
			neg_s4[k] <= neg_s3[k];
			mag_s4[k] <= byp_s3 ? mag_s3[k] : gval[k];
			out_s5[k] <= sres[k][IW-1:0];
		end
	end

	assign out_valid = v_s5;
	assign a_out     = out_s5[0];
	assign b_out     = out_s5[1];
	assign side_out  = side_s5;

	`ASSERT_DELAY(a_rot_latency, clk, arst_n, in_valid, LAT, out_valid)
	`ASSERT_IMPL(a_rot_origin, clk, arst_n, out_valid, $past(in_valid, LAT))
	`ASSERT_DELAY(a_rot_zero_exact, clk, arst_n, in_valid && (angle == '0), LAT, (a_out == $past(a_in, LAT)) && (b_out == $past(b_in, LAT)))

endmodule

FILE: sv/euler_rotate_xyz_3d.sv
// done pulses once a taken start has passed the X, Y and Z rotations and the output register.
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// Each axis is one pass of quadrant stage, one stage per micro-rotation, four gain stages.
// Reset clears only the valid bits; results in flight are dropped.
`include "assert_macros.svh"

module euler_rotate_xyz_3d #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  logic [ANGLE_BITS-1:0]         angle_about_x,
	input  logic [ANGLE_BITS-1:0]         angle_about_y,
	input  logic [ANGLE_BITS-1:0]         angle_about_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz,
	output logic                          saturated
);
	import eul_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int AB = ANGLE_BITS;
	localparam int NST = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	localparam int IW = W + GUARD_BITS + 3;
	localparam int HEAD = IW - W - GUARD_BITS;
	localparam int SW = IW + 1 - GUARD_BITS;
	localparam int LAT = 3 * (NST + 5) + 1;
	localparam logic [W-1:0] MAXC = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINC = {1'b1, {(W-1){1'b0}}};

	assign busy = 1'b0;

	// widen coordinates with guard bits
	logic signed [IW-1:0] x0, y0, z0;
	assign x0 = {{HEAD{px[W-1]}}, px, {GUARD_BITS{1'b0}}};
	assign y0 = {{HEAD{py[W-1]}}, py, {GUARD_BITS{1'b0}}};
	assign z0 = {{HEAD{pz[W-1]}}, pz, {GUARD_BITS{1'b0}}};

	// about X on (y, z)
	logic                 v1;
	logic signed [IW-1:0] y1, z1;
	logic [IW+2*AB-1:0]   side1;

	eul_rot #(.IW(IW), .ANGLE_BITS(AB), .NST(NST), .PW(IW + 2 * AB)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.a_in(y0), .b_in(z0), .angle(angle_about_x),
		.side_in({x0, angle_about_y, angle_about_z}),
		.out_valid(v1), .a_out(y1), .b_out(z1), .side_out(side1)
	);

	// about Y on (z, x)
	logic                 v2;
	logic signed [IW-1:0] z2, x2;
	logic [IW+AB-1:0]     side2;

	eul_rot #(.IW(IW), .ANGLE_BITS(AB), .NST(NST), .PW(IW + AB)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .in_valid(v1),
		.a_in(z1), .b_in(side1[IW+2*AB-1:2*AB]), .angle(side1[2*AB-1:AB]),
		.side_in({y1, side1[AB-1:0]}),
		.out_valid(v2), .a_out(z2), .b_out(x2), .side_out(side2)
	);

	// about Z on (x, y)
	logic                 v3;
	logic signed [IW-1:0] x3, y3;
	logic [IW-1:0]        side3;

	eul_rot #(.IW(IW), .ANGLE_BITS(AB), .NST(NST), .PW(IW)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .in_valid(v2),
		.a_in(x2), .b_in(side2[IW+AB-1:AB]), .angle(side2[AB-1:0]),
		.side_in(z2),
		.out_valid(v3), .a_out(x3), .b_out(y3), .side_out(side3)
	);

	// round off guard bits and clamp
	logic signed [IW-1:0] fin [3];
	logic signed [IW:0]   sum [3];
	logic [SW-1:0]        sh [3];
	logic                 fits [3];
	logic [W-1:0]         clamp [3];

	assign fin[0] = x3;
	assign fin[1] = y3;
	assign fin[2] = side3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = {fin[k][IW-1], fin[k]} + (IW+1)'(1 << (GUARD_BITS - 1));
			sh[k] = sum[k][IW:GUARD_BITS];
			fits[k] = (&sh[k][SW-1:W-1]) || !(|sh[k][SW-1:W-1]);
			clamp[k] = fits[k] ? sh[k][W-1:0] : (sh[k][SW-1] ? MINC : MAXC);
		end
	end

	// register the done flag and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v3;
		end
	end

	always_ff @(posedge clk) begin
		rx        <= clamp[0];
		ry        <= clamp[1];
		rz        <= clamp[2];
		saturated <= !(fits[0] && fits[1] && fits[2]);
	end

	`ASSERT_DELAY(a_top_latency, clk, arst_n, start && !busy, LAT, done)
	`ASSERT_IMPL(a_top_origin, clk, arst_n, done, $past(start && !busy, LAT))
	`ASSERT_IMPL(a_top_clamp, clk, arst_n, done && saturated, rx == MAXC || rx == MINC || ry == MAXC || ry == MINC || rz == MAXC || rz == MINC)

endmodule
